// ----- hdl/pols_pkg.sv -----
// ----------------------------------------------------------------------------
// pols_pkg
// Shared types and codes for the positional ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

package pols_pkg;

    // Widths fixed by the transaction fields; CAPACITY must not exceed 64, which nothing here enforces.
    localparam int unsigned POS_W = 6;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned VAL_W = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_INS_AT    = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_BADPOS    = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'b001,
        FSM_SEARCH = 3'b010,
        FSM_DUMP   = 3'b100
    } fsm_t;

    typedef enum logic [2:0] {
        CH_HOLD    = 3'd0,
        CH_INSERT  = 3'd1,
        CH_REMOVE  = 3'd2,
        CH_ROTATE  = 3'd3,
        CH_COMPARE = 3'd4
    } chain_cmd_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        chain_cmd_t        cmd;
        logic [POS_W-1:0]  idx;    // target slot for insert / remove
        logic [POS_W-1:0]  tail;   // last occupied slot, for rotate
        logic [CNT_W-1:0]  cnt;    // occupancy, for compare masking
        logic [VAL_W-1:0]  value;  // value to insert or key to compare
    } chain_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/pols_cmd_if.sv -----
// ----------------------------------------------------------------------------
// pols_cmd_if
// Command channel: operation, value and position with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pols_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [5:0]         position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/pols_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pols_rsp_if
// Response channel: status, element, positions, count and last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface pols_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [6:0]         found_position;
    logic [6:0]         element_count;
    logic               last;

    modport source (output valid, output status, output element, output found_position,
                    output element_count, output last, input ready);
    modport sink   (input valid, input status, input element, input found_position,
                    input element_count, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/pols_cell.sv -----
// ----------------------------------------------------------------------------
// pols_cell
// One slot of the list: holds an element, shifts with its neighbors, compares.
// ----------------------------------------------------------------------------
`default_nettype none

module pols_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                       clk,
    input  wire pols_pkg::chain_ctrl_t      ctrl,
    input  wire logic [pols_pkg::VAL_W-1:0] left_val,
    input  wire logic [pols_pkg::VAL_W-1:0] right_val,
    input  wire logic [pols_pkg::VAL_W-1:0] head_val,
    output logic      [pols_pkg::VAL_W-1:0] val,
    output logic                            match
);

    localparam logic [pols_pkg::POS_W-1:0] IDX = pols_pkg::POS_W'(INDEX);

    logic [pols_pkg::VAL_W-1:0] val_reg;
    logic [pols_pkg::VAL_W-1:0] val_next;
    logic                       match_reg;
    logic                       match_next;

    always_comb
    begin
        val_next   = val_reg;
        match_next = match_reg;
        unique case (ctrl.cmd)
            pols_pkg::CH_INSERT:
            begin
                if (IDX == ctrl.idx)
                    val_next = ctrl.value;
                else if (IDX > ctrl.idx)
                    val_next = left_val;
            end
            pols_pkg::CH_REMOVE:
            begin
                if (IDX >= ctrl.idx)
                    val_next = right_val;
            end
            pols_pkg::CH_ROTATE:
            begin
                // Wrap the head into the tail slot, advance every slot below the tail.
                if (IDX == ctrl.tail)
                    val_next = head_val;
                else if (IDX < ctrl.tail)
                    val_next = right_val;
            end
            pols_pkg::CH_COMPARE:
            begin
                match_next = (val_reg == ctrl.value) && ({1'b0, IDX} < ctrl.cnt);
            end
            default:
            begin
                val_next   = val_reg;
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        match_reg <= match_next;
    end

    assign val   = val_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ----- hdl/positional_ordered_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list_store
// Ordered list of signed 32-bit values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Timing: inserts and deletes register their result on acceptance; a search
//   compares in every cell, then first-hit encodes the registered matches.
// Throughput: 1 transaction per cycle for inserts and deletes while the
//   response slot is free; a search holds the command channel until its
//   result is loaded; a dump holds it for the accept cycle, then one element
//   per cycle from the head cell, while the chain rotates and the slot is free.
// Reset: rst_n clears the element count, FSM and response valid; cell contents
//   are left as they are and never read beyond the count.
`default_nettype none

module positional_ordered_list_store #(
    parameter int CAPACITY = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pols_cmd_if.sink    cmd,
    pols_rsp_if.source  rsp
);

    localparam int unsigned POS_W = pols_pkg::POS_W;
    localparam int unsigned CNT_W = pols_pkg::CNT_W;
    localparam int unsigned VAL_W = pols_pkg::VAL_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control state
    pols_pkg::fsm_t      state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    dump_idx_reg, dump_idx_next;
    logic                out_valid_reg, out_valid_next;

    // Response payload
    logic [2:0]          status_reg, status_next;
    logic [VAL_W-1:0]    element_reg, element_next;
    logic [CNT_W-1:0]    fpos_reg, fpos_next;
    logic [CNT_W-1:0]    ecount_reg, ecount_next;
    logic                last_reg, last_next;

    // Chain
    pols_pkg::chain_ctrl_t ctrl;
    logic [VAL_W-1:0]    cell_val   [CAPACITY];
    logic [VAL_W-1:0]    left_val   [CAPACITY];
    logic [VAL_W-1:0]    right_val  [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic                out_free;
    logic                accept;
    logic                out_load;
    logic [CNT_W-1:0]    pos_ext;
    logic                hit;
    logic [CNT_W-1:0]    hit_pos;
    logic [CNT_W-1:0]    dump_pos;
    pols_pkg::op_t       op;

    // Output slot frees up when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == pols_pkg::FSM_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign op        = pols_pkg::op_t'(cmd.operation);
    assign pos_ext   = {1'b0, cmd.position};
    assign dump_pos  = dump_idx_reg + CNT_W'(1);

    // First hit of the registered match vector, lowest slot wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_pos = CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        dump_idx_next = dump_idx_reg;
        out_load      = 1'b0;
        status_next   = status_reg;
        element_next  = element_reg;
        fpos_next     = fpos_reg;
        ecount_next   = ecount_reg;
        last_next     = last_reg;

        ctrl.cmd   = pols_pkg::CH_HOLD;
        ctrl.idx   = '0;
        ctrl.tail  = POS_W'(cnt_reg - CNT_W'(1));
        ctrl.cnt   = cnt_reg;
        ctrl.value = cmd.value;

        unique case (state_reg)
            pols_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    // Default: one result, ok, nothing emitted.
                    out_load     = 1'b1;
                    status_next  = pols_pkg::STS_OK;
                    element_next = '0;
                    fpos_next    = '0;
                    last_next    = 1'b1;
                    unique case (op)
                        pols_pkg::OP_INS_FRONT,
                        pols_pkg::OP_INS_BACK:
                        begin
                            if (cnt_reg == CAP_CNT)
                                status_next = pols_pkg::STS_FULL;
                            else
                            begin
                                ctrl.cmd = pols_pkg::CH_INSERT;
                                ctrl.idx = (op == pols_pkg::OP_INS_FRONT)
                                           ? '0 : POS_W'(cnt_reg);
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        pols_pkg::OP_DEL_FRONT,
                        pols_pkg::OP_DEL_BACK:
                        begin
                            if (cnt_reg == '0)
                                status_next = pols_pkg::STS_EMPTY;
                            else
                            begin
                                ctrl.cmd = pols_pkg::CH_REMOVE;
                                ctrl.idx = (op == pols_pkg::OP_DEL_FRONT)
                                           ? '0 : POS_W'(cnt_reg - CNT_W'(1));
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        pols_pkg::OP_INS_AT:
                        begin
                            // Position check ranks ahead of the full check.
                            if (pos_ext == '0 || pos_ext > cnt_reg + CNT_W'(1))
                                status_next = pols_pkg::STS_BADPOS;
                            else if (cnt_reg == CAP_CNT)
                                status_next = pols_pkg::STS_FULL;
                            else
                            begin
                                ctrl.cmd = pols_pkg::CH_INSERT;
                                ctrl.idx = cmd.position - POS_W'(1);
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        pols_pkg::OP_DEL_AT:
                        begin
                            if (cnt_reg == '0)
                                status_next = pols_pkg::STS_EMPTY;
                            else if (pos_ext == '0 || pos_ext > cnt_reg)
                                status_next = pols_pkg::STS_BADPOS;
                            else
                            begin
                                ctrl.cmd = pols_pkg::CH_REMOVE;
                                ctrl.idx = cmd.position - POS_W'(1);
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        pols_pkg::OP_SEARCH:
                        begin
                            if (cnt_reg == '0)
                                status_next = pols_pkg::STS_EMPTY;
                            else
                            begin
                                // Hold the result until the match vector settles.
                                out_load   = 1'b0;
                                ctrl.cmd   = pols_pkg::CH_COMPARE;
                                state_next = pols_pkg::FSM_SEARCH;
                            end
                        end
                        pols_pkg::OP_DUMP:
                        begin
                            if (cnt_reg == '0)
                                status_next = pols_pkg::STS_EMPTY;
                            else
                            begin
                                out_load      = 1'b0;
                                dump_idx_next = '0;
                                state_next    = pols_pkg::FSM_DUMP;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                    ecount_next = cnt_next;
                end
            end
            pols_pkg::FSM_SEARCH:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    status_next  = hit ? pols_pkg::STS_OK : pols_pkg::STS_NOT_FOUND;
                    element_next = '0;
                    fpos_next    = hit ? hit_pos : '0;
                    ecount_next  = cnt_reg;
                    last_next    = 1'b1;
                    state_next   = pols_pkg::FSM_IDLE;
                end
            end
            pols_pkg::FSM_DUMP:
            begin
                if (out_free)
                begin
                    // Emit the head and rotate; after count steps order is restored.
                    out_load      = 1'b1;
                    status_next   = pols_pkg::STS_OK;
                    element_next  = cell_val[0];
                    fpos_next     = dump_pos;
                    ecount_next   = cnt_reg;
                    last_next     = (dump_pos == cnt_reg);
                    ctrl.cmd      = pols_pkg::CH_ROTATE;
                    dump_idx_next = dump_pos;
                    if (dump_pos == cnt_reg)
                        state_next = pols_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = pols_pkg::FSM_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pols_pkg::FSM_IDLE;
            cnt_reg       <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        fpos_reg    <= fpos_next;
        ecount_reg  <= ecount_next;
        last_reg    <= last_next;
    end

    // Cell chain: slot 0 is the front of the list.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_left_edge
            assign left_val[g] = cell_val[g];
        end
        else
        begin : g_left
            assign left_val[g] = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_right_edge
            assign right_val[g] = cell_val[g];
        end
        else
        begin : g_right
            assign right_val[g] = cell_val[g+1];
        end

        pols_cell #(
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .left_val  (left_val[g]),
            .right_val (right_val[g]),
            .head_val  (cell_val[0]),
            .val       (cell_val[g]),
            .match     (match_vec[g])
        );
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.element        = element_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.element_count  = ecount_reg;
    assign rsp.last           = last_reg;

endmodule

`default_nettype wire

// ----- hdl/pols_checker.sv -----
// ----------------------------------------------------------------------------
// pols_checker
// Port-level checks for the positional ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

module pols_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [31:0] rsp_element,
    input wire logic [6:0]  rsp_found_position,
    input wire logic [6:0]  rsp_element_count,
    input wire logic        rsp_last
);

    localparam logic [6:0] CAP_CNT = 7'(CAPACITY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element)
            && $stable(rsp_status) && $stable(rsp_last))
        else $error("response changed while stalled");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_element_count <= CAP_CNT && rsp_found_position <= CAP_CNT)
        else $error("count or position beyond capacity");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != pols_pkg::STS_OK |-> rsp_last
            && rsp_element == '0 && rsp_found_position == '0)
        else $error("error response not a single zeroed result");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !cmd_ready)
        else $error("command accepted in the middle of a dump");

    a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |->
            rsp_found_position == $past(rsp_found_position) + 7'd1)
        else $error("dump positions out of order");

endmodule

bind positional_ordered_list_store pols_checker #(
    .CAPACITY (CAPACITY)
) u_pols_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_element        (rsp.element),
    .rsp_found_position (rsp.found_position),
    .rsp_element_count  (rsp.element_count),
    .rsp_last           (rsp.last)
);

`default_nettype wire

// ----- tb/pols_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pols_reply_checker
// Watches the command and response channels of the list store, keeps its own
// copy of the list, predicts every reply and compares each one field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pols_reply_checker
    import pols_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pols_cmd_if         cmd,
    pols_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic [6:0]         found_position;
        logic [6:0]         element_count;
        logic               last;
    } reply_t;

    logic signed [31:0] list_mirror[$];
    reply_t             expected_replies[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns  reply check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic push_reply(input status_t st, input logic signed [31:0] elem,
                              input logic [6:0] fpos, input logic lst);
        reply_t r;
        r.status         = st;
        r.element        = elem;
        r.found_position = fpos;
        r.element_count  = 7'(list_mirror.size());
        r.last           = lst;
        expected_replies.push_back(r);
    endtask

    // Apply one command to the mirror and queue the replies it must cause.
    task automatic apply_command(input op_t op, input logic signed [31:0] val,
                                 input logic [5:0] pos);
        status_t    st;
        logic [6:0] hit;
        int         n;
        int         p;
        st  = STS_OK;
        hit = '0;
        n   = list_mirror.size();
        p   = int'(pos);
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (n >= CAPACITY)
                    st = STS_FULL;
                else if (op == OP_INS_FRONT)
                    list_mirror.push_front(val);
                else
                    list_mirror.push_back(val);
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (n == 0)
                    st = STS_EMPTY;
                else if (op == OP_DEL_FRONT)
                    void'(list_mirror.pop_front());
                else
                    void'(list_mirror.pop_back());
            end
            OP_INS_AT:
            begin
                // Position is checked before the full condition.
                if (p == 0 || p > n + 1)
                    st = STS_BADPOS;
                else if (n >= CAPACITY)
                    st = STS_FULL;
                else
                    list_mirror.insert(p - 1, val);
            end
            OP_DEL_AT:
            begin
                if (n == 0)
                    st = STS_EMPTY;
                else if (p == 0 || p > n)
                    st = STS_BADPOS;
                else
                    list_mirror.delete(p - 1);
            end
            OP_SEARCH:
            begin
                if (n == 0)
                    st = STS_EMPTY;
                else
                begin
                    st = STS_NOT_FOUND;
                    for (int i = 0; i < n; i++)
                    begin
                        if (list_mirror[i] == val && hit == '0)
                        begin
                            st  = STS_OK;
                            hit = 7'(i + 1);
                        end
                    end
                end
            end
            default:
            begin
                if (n == 0)
                    st = STS_EMPTY;
            end
        endcase
        if (op == OP_DUMP && n != 0)
        begin
            for (int i = 0; i < n; i++)
                push_reply(STS_OK, list_mirror[i], 7'(i + 1), (i + 1 == n));
        end
        else
            push_reply(st, '0, hit, 1'b1);
    endtask

    task automatic check_reply();
        reply_t e;
        if (expected_replies.size() == 0)
        begin
            report_mismatch($sformatf("unexpected reply status=%0d element=%0d",
                                      rsp.status, rsp.element));
        end
        else
        begin
            e = expected_replies.pop_front();
            if (rsp.status !== e.status)
                report_mismatch($sformatf("status got %0d want %0d", rsp.status, e.status));
            if (rsp.element !== e.element)
                report_mismatch($sformatf("element got %0d want %0d", rsp.element, e.element));
            if (rsp.found_position !== e.found_position)
                report_mismatch($sformatf("found_position got %0d want %0d",
                                          rsp.found_position, e.found_position));
            if (rsp.element_count !== e.element_count)
                report_mismatch($sformatf("element_count got %0d want %0d",
                                          rsp.element_count, e.element_count));
            if (rsp.last !== e.last)
                report_mismatch($sformatf("last got %0b want %0b", rsp.last, e.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_mirror.delete();
            expected_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_reply();
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                apply_command(op_t'(cmd.operation), cmd.value, cmd.position);
            outstanding = expected_replies.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the list store with a directed opening and phased random traffic,
// throttles both channels, and gives the verdict from the reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import pols_pkg::*;

    localparam int          DEPTH       = 32;
    localparam int          RANDOM_CMDS = 440;
    // Worst case is far below this: every command a full dump with every
    // reply held for the longest stall still ends well inside the bound.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    bit          calm  = 1'b0;   // set to suppress idling on both channels
    int unsigned cycle_count = 0;
    int unsigned fail_count;
    int unsigned outstanding;

    pols_cmd_if cmd ();
    pols_rsp_if rsp ();

    positional_ordered_list_store #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    pols_reply_checker #(
        .CAPACITY (DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response backpressure: drop ready in random bursts unless calm.
    always
    begin
        @(posedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        rsp.ready <= 1'b1;
    end

    // Present one transaction and hold it until the store accepts it.
    // Return on the accepting edge with valid still high.
    task automatic send_cmd(input op_t op, input logic signed [31:0] val,
                            input logic [5:0] pos);
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.value     <= val;
        cmd.position  <= pos;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
    endtask

    // Insert a gap after an accepted transaction now and then.
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Mostly small values from a narrow pool so that searches hit, with
    // extremes and full-width values mixed in.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2, 3:    v = $urandom;
            default: v = 32'(int'($urandom_range(0, 11)) - 4);
        endcase
        return v;
    endfunction

    // Keep positions near the live range; reach the full field at times.
    function automatic logic [5:0] pick_position();
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, DEPTH + 2));
    endfunction

    function automatic op_t pick_op(input int unsigned ins_pct, input int unsigned del_pct);
        int unsigned r;
        op_t         op;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FRONT;
                1:       op = OP_INS_BACK;
                default: op = OP_INS_AT;
            endcase
        end
        else if (r < ins_pct + del_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_DEL_FRONT;
                1:       op = OP_DEL_BACK;
                default: op = OP_DEL_AT;
            endcase
        end
        else if ($urandom_range(0, 2) == 0)
            op = OP_DUMP;
        else
            op = OP_SEARCH;
        return op;
    endfunction

    task automatic directed_cmds();
        // Empty list: every read or removal reports empty, a dump one reply.
        send_cmd(OP_DUMP,      32'sd0, 6'd0);  maybe_idle();
        send_cmd(OP_DEL_FRONT, 32'sd0, 6'd0);  maybe_idle();
        send_cmd(OP_DEL_BACK,  32'sd0, 6'd0);  maybe_idle();
        send_cmd(OP_DEL_AT,    32'sd0, 6'd3);  maybe_idle();
        send_cmd(OP_SEARCH,    32'sd0, 6'd0);  maybe_idle();
        // Positional insert above 1 into an empty list, and position zero.
        send_cmd(OP_INS_AT,    32'sd9, 6'd2);  maybe_idle();
        send_cmd(OP_INS_AT,    32'sd9, 6'd0);  maybe_idle();
        // Build a short list from the value extremes.
        send_cmd(OP_INS_AT,    32'sh8000_0000, 6'd1);  maybe_idle();
        send_cmd(OP_INS_FRONT, 32'sh7fff_ffff, 6'd0);  maybe_idle();
        send_cmd(OP_INS_BACK,  -32'sd1,        6'd0);  maybe_idle();
        // Insert at one past the end appends.
        send_cmd(OP_INS_AT,    32'sd0,  6'd4);  maybe_idle();
        send_cmd(OP_INS_AT,    32'sd5,  6'd63); maybe_idle();
        send_cmd(OP_DEL_AT,    32'sd0,  6'd0);  maybe_idle();
        send_cmd(OP_DEL_AT,    32'sd0,  6'd5);  maybe_idle();
        send_cmd(OP_SEARCH,    32'sh7fff_ffff, 6'd0);  maybe_idle();
        send_cmd(OP_SEARCH,    32'sd12345,     6'd0);  maybe_idle();
        // Duplicate key: search must report the first holder.
        send_cmd(OP_INS_BACK,  -32'sd1, 6'd0);  maybe_idle();
        send_cmd(OP_SEARCH,    -32'sd1, 6'd63); maybe_idle();
        send_cmd(OP_DUMP,      32'sd0,  6'd0);  maybe_idle();
        send_cmd(OP_DEL_AT,    32'sd0,  6'd2);  maybe_idle();
        send_cmd(OP_DEL_FRONT, 32'sd0,  6'd0);  maybe_idle();
        send_cmd(OP_DEL_BACK,  32'sd0,  6'd0);  maybe_idle();
        send_cmd(OP_DUMP,      32'sd0,  6'd0);  maybe_idle();
    endtask

    // Phased traffic: fill past full, churn, drain past empty, refill, churn.
    task automatic random_cmds();
        int unsigned ins_pct;
        int unsigned del_pct;
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            if (k < 60)
            begin
                ins_pct = 85; del_pct = 10;
            end
            else if (k < 140)
            begin
                ins_pct = 45; del_pct = 40;
            end
            else if (k < 200)
            begin
                ins_pct = 10; del_pct = 80;
            end
            else if (k < 280)
            begin
                ins_pct = 80; del_pct = 12;
            end
            else
            begin
                ins_pct = 47; del_pct = 40;
            end
            // Hold both channels busy in one middle stretch and at the end.
            calm = (k >= 300 && k < 330) || (k >= 380);
            send_cmd(pick_op(ins_pct, del_pct), pick_value(), pick_position());
            maybe_idle();
        end
    endtask

    initial
    begin
        cmd.valid     = 1'b0;
        cmd.operation = OP_INS_FRONT;
        cmd.value     = '0;
        cmd.position  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_cmds();
        random_cmds();
        cmd.valid <= 1'b0;

        // Let the checker see the final acceptance, then drain the replies.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/pols_pkg.sv
hdl/pols_cmd_if.sv
hdl/pols_rsp_if.sv
hdl/pols_cell.sv
hdl/positional_ordered_list_store.sv
hdl/pols_checker.sv
tb/pols_reply_checker.sv
tb/tb.sv
